// ===== design/crgb_pkg.sv =====
// Shared widths, register map and arithmetic helpers for the chromaticity to RGB converter.
package crgb_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CW     = 16;
    localparam int ZW     = CW + 2;
    localparam int MW     = 2 * ZW + 1;
    localparam int DW     = MW + ZW + 2;
    localparam int MAGW   = DW - 1;
    localparam int PW     = MAGW + CW;
    localparam int NW     = PW + FRAC_BITS;
    localparam int OUT_W  = 20;
    localparam int QB     = OUT_W + 1;
    localparam int R0W    = NW - QB;
    localparam int S_TDW  = ((3 * CW + 7) / 8) * 8;
    localparam int M_TDW  = ((3 * OUT_W + 7) / 8) * 8;

    localparam int OUT_MAX     = 2 ** (OUT_W - 1) - 1;
    localparam int OUT_MIN_MAG = 2 ** (OUT_W - 1);

    localparam int NUM_REGS = 8;
    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam int CFG_IW   = REG_AW + 1;

    localparam logic [REG_AW-1:0] REG_RED_X   = REG_AW'(0);
    localparam logic [REG_AW-1:0] REG_RED_Y   = REG_AW'(1);
    localparam logic [REG_AW-1:0] REG_GREEN_X = REG_AW'(2);
    localparam logic [REG_AW-1:0] REG_GREEN_Y = REG_AW'(3);
    localparam logic [REG_AW-1:0] REG_BLUE_X  = REG_AW'(4);
    localparam logic [REG_AW-1:0] REG_BLUE_Y  = REG_AW'(5);
    localparam logic [REG_AW-1:0] REG_WHITE_X = REG_AW'(6);
    localparam logic [REG_AW-1:0] REG_WHITE_Y = REG_AW'(7);

    localparam logic [CW-1:0] CFG_RST [NUM_REGS] = '{
        16'd41943, 16'd21627, 16'd19661, 16'd39322,
        16'd9830,  16'd3932,  16'd20493, 16'd21561
    };

    localparam logic signed [ZW-1:0] UNIT_Z = ZW'(1 << CW);

    typedef logic signed [ZW-1:0] t_coord;
    typedef logic signed [MW-1:0] t_mat;
    typedef logic signed [DW-1:0] t_dot;

    typedef struct packed {
        logic ovf;
        logic neg;
    } t_div_tag;

    function automatic t_coord to_sz(logic [CW-1:0] x);
        return signed'({2'b00, x});
    endfunction

    // Third coordinate: one minus the other two, may go negative.
    function automatic t_coord coord_z(logic [CW-1:0] x, logic [CW-1:0] y);
        t_coord sx;
        t_coord sy;
        sx = to_sz(x);
        sy = to_sz(y);
        return UNIT_Z - sx - sy;
    endfunction

    function automatic t_mat cross2(t_coord a, t_coord b, t_coord c, t_coord d);
        t_mat p0;
        t_mat p1;
        p0 = a * b;
        p1 = c * d;
        return p0 - p1;
    endfunction

    function automatic t_dot mul_dot(t_mat m, t_coord v);
        t_dot p;
        p = m * v;
        return p;
    endfunction

endpackage

// ===== design/crgb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module crgb_div (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [crgb_pkg::MAGW-1:0] i_rem,
    input  logic [crgb_pkg::QB-1:0]   i_bits,
    input  logic [crgb_pkg::MAGW-1:0] i_dmag,
    input  crgb_pkg::t_div_tag        i_tag,
    output logic [crgb_pkg::MAGW-1:0] o_rem,
    output logic [crgb_pkg::QB-1:0]   o_quo,
    output crgb_pkg::t_div_tag        o_tag
);
    import crgb_pkg::*;

    logic [MAGW-1:0] r_rem [QB];
    logic [QB-1:0]   r_quo [QB];
    t_div_tag        r_tag [QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [MAGW-1:0] src_rem;
        logic [QB-1:0]   src_quo;
        t_div_tag        src_tag;
        logic [MAGW:0]   trial;
        logic            fits;

        if (k == 0) begin : g_first
            assign src_rem = i_rem;
            assign src_quo = i_bits;
            assign src_tag = i_tag;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_quo = r_quo[k-1];
            assign src_tag = r_tag[k-1];
        end

        // shift in the next dividend bit from the top of the quotient word
        assign trial = {src_rem, src_quo[QB-1]};
        assign fits  = trial >= {1'b0, i_dmag};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= fits ? MAGW'(trial - {1'b0, i_dmag}) : MAGW'(trial);
                r_quo[k] <= {src_quo[QB-2:0], fits};
                r_tag[k] <= src_tag;
            end
        end
    end

    assign o_rem = r_rem[QB-1];
    assign o_quo = r_quo[QB-1];
    assign o_tag = r_tag[QB-1];

endmodule

// ===== design/chromaticity_to_rgb_converter.sv =====
// Top level of the chromaticity (x, y, z) to linear RGB converter.
//
// Usage:
//   Slave stream: tdata carries chroma_x, chroma_y, chroma_z (unsigned Q0.16).
//   Master stream: tdata carries red, green, blue (signed Q4.16, saturated),
//   tuser carries the degenerate flag; a degenerate transfer has all colors zero.
//   Configuration: write enable, register index and 16-bit data; indices 0..7
//   select red_x, red_y, green_x, green_y, blue_x, blue_y, white_x, white_y.
//   Write them only while no transfer is in flight.
// Timing:
//   One transfer is accepted per clock while the skid register is empty. A result
//   passes through 7 arithmetic stages, a 21-stage divider (one quotient bit
//   per stage per color) and a rounding stage before the output register.
//   The matrix and white-point scale are recomputed from the registers in a
//   free-running 4-stage chain that stays ahead of the data pipeline.
// Reset and stall:
//   Synchronous reset loads the default primaries and empties the pipeline.
//   When the receiver stalls, a skid register catches one result; the pipeline
//   holds only once the skid is full, so nothing is dropped or repeated.
module chromaticity_to_rgb_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [crgb_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [crgb_pkg::CW-1:0]       i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // chroma_x [15:0], chroma_y [31:16], chroma_z [47:32]
    input  logic [crgb_pkg::S_TDW-1:0]    i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // red_out [19:0], green_out [39:20], blue_out [59:40], zeros above
    output logic [crgb_pkg::M_TDW-1:0]    o_m_axis_tdata,
    // degenerate [0]
    output logic [0:0]                    o_m_axis_tuser
);
    import crgb_pkg::*;

    localparam int DIV0 = 7;
    localparam int NST  = DIV0 + QB + 1;

    // ---------------- configuration registers ----------------
    logic [CW-1:0] r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_cfg_we && i_cfg_idx < CFG_IW'(NUM_REGS)) begin
            r_cfg[i_cfg_idx[REG_AW-1:0]] <= i_cfg_wdata;
        end
    end

    // ---------------- derived matrix chain (free running) ----------------
    t_mat   n_mat [3][3];
    t_mat   r_mat [3][3];
    t_coord wv    [3];
    t_dot   r_dp  [3][3];
    t_dot   r_den [3];
    logic [MAGW-1:0] r_dmag [3];
    logic   r_deg;

    always_comb begin
        t_coord xr, yr, zr, xg, yg, zg, xb, yb, zb;
        xr = to_sz(r_cfg[REG_RED_X]);
        yr = to_sz(r_cfg[REG_RED_Y]);
        zr = coord_z(r_cfg[REG_RED_X], r_cfg[REG_RED_Y]);
        xg = to_sz(r_cfg[REG_GREEN_X]);
        yg = to_sz(r_cfg[REG_GREEN_Y]);
        zg = coord_z(r_cfg[REG_GREEN_X], r_cfg[REG_GREEN_Y]);
        xb = to_sz(r_cfg[REG_BLUE_X]);
        yb = to_sz(r_cfg[REG_BLUE_Y]);
        zb = coord_z(r_cfg[REG_BLUE_X], r_cfg[REG_BLUE_Y]);
        // rows of the inverse primary matrix as cross products
        n_mat[0][0] = cross2(yg, zb, yb, zg);
        n_mat[0][1] = cross2(xb, zg, xg, zb);
        n_mat[0][2] = cross2(xg, yb, xb, yg);
        n_mat[1][0] = cross2(yb, zr, yr, zb);
        n_mat[1][1] = cross2(xr, zb, xb, zr);
        n_mat[1][2] = cross2(xb, yr, xr, yb);
        n_mat[2][0] = cross2(yr, zg, yg, zr);
        n_mat[2][1] = cross2(xg, zr, xr, zg);
        n_mat[2][2] = cross2(xr, yg, xg, yr);
        wv[0] = to_sz(r_cfg[REG_WHITE_X]);
        wv[1] = to_sz(r_cfg[REG_WHITE_Y]);
        wv[2] = coord_z(r_cfg[REG_WHITE_X], r_cfg[REG_WHITE_Y]);
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                r_dp[r][j] <= mul_dot(r_mat[r][j], wv[j]);
            end
            r_den[r]  <= r_dp[r][0] + r_dp[r][1] + r_dp[r][2];
            r_dmag[r] <= r_den[r][DW-1] ? MAGW'(-r_den[r]) : MAGW'(r_den[r]);
        end
        r_deg <= (r_cfg[REG_WHITE_Y] == '0) || (r_den[0] == '0)
                 || (r_den[1] == '0) || (r_den[2] == '0);
    end

    // ---------------- data pipeline ----------------
    logic            adv;
    logic [NST-1:0]  r_vld;
    logic [CW-1:0]   r_c0 [3];
    logic [CW-1:0]   r_c1 [3];
    t_dot            r_sp [3][3];
    t_dot            r_s  [3];
    logic [MAGW-1:0] r_smag [3];
    logic [2:0]      r_neg4;
    logic [PW-1:0]   r_prod [3];
    logic [2:0]      r_neg5;
    logic [MAGW-1:0] r_rem0 [3];
    logic [QB-1:0]   r_nlow [3];
    t_div_tag        r_tag6 [3];
    logic [MAGW-1:0] div_rem [3];
    logic [QB-1:0]   div_quo [3];
    t_div_tag        div_tag [3];
    logic [M_TDW-1:0] r_rdata;
    logic            r_rdeg;

    // output register and skid state
    logic             r_out_vld;
    logic [M_TDW-1:0] r_out_data;
    logic             r_out_user;
    logic             r_skid_vld;
    logic [M_TDW-1:0] r_skid_data;
    logic             r_skid_user;
    logic             take;
    logic             pipe_out;

    // advance the data pipeline and the dividers while the skid register is free
    assign adv             = !r_skid_vld;
    assign o_s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] num;
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_c0[j] <= i_s_axis_tdata[j*CW +: CW];
                r_c1[j] <= r_c0[j];
            end
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_sp[r][j] <= mul_dot(r_mat[r][j], to_sz(r_c1[j]));
                end
                r_s[r]    <= r_sp[r][0] + r_sp[r][1] + r_sp[r][2];
                r_smag[r] <= r_s[r][DW-1] ? MAGW'(-r_s[r]) : MAGW'(r_s[r]);
                r_neg4[r] <= r_s[r][DW-1] ^ r_den[r][DW-1];
                r_prod[r] <= PW'(r_smag[r]) * PW'(r_cfg[REG_WHITE_Y]);
                r_neg5[r] <= r_neg4[r];
                // dividend = |S| * white_y * 2^FRAC_BITS; top part seeds the remainder
                num           = {r_prod[r], FRAC_BITS'(0)};
                r_tag6[r].ovf <= num[NW-1:QB] >= {(R0W-MAGW)'(0), r_dmag[r]};
                r_tag6[r].neg <= r_neg5[r];
                r_rem0[r]     <= MAGW'(num[NW-1:QB]);
                r_nlow[r]     <= num[QB-1:0];
            end
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        crgb_div u_div (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_rem  (r_rem0[r]),
            .i_bits (r_nlow[r]),
            .i_dmag (r_dmag[r]),
            .i_tag  (r_tag6[r]),
            .o_rem  (div_rem[r]),
            .o_quo  (div_quo[r]),
            .o_tag  (div_tag[r])
        );
    end

    // round half away from zero, apply sign, saturate
    function automatic logic [OUT_W-1:0] round_sat(logic [QB-1:0] q, logic [MAGW-1:0] rem,
                                                   logic [MAGW-1:0] dmag, t_div_tag tag);
        logic [QB:0] qr;
        logic [QB:0] qn;
        logic        up;
        up = {rem, 1'b0} >= {1'b0, dmag};
        qr = {1'b0, q} + (QB+1)'(up);
        qn = (QB+1)'(0) - qr;
        if (!tag.neg) begin
            if (tag.ovf || qr > (QB+1)'(OUT_MAX)) begin
                return OUT_W'(OUT_MAX);
            end
            return qr[OUT_W-1:0];
        end
        if (tag.ovf || qr > (QB+1)'(OUT_MIN_MAG)) begin
            return OUT_W'(OUT_MIN_MAG);
        end
        return qn[OUT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rdeg <= r_deg;
            if (r_deg) begin
                r_rdata <= '0;
            end else begin
                r_rdata <= {(M_TDW-3*OUT_W)'(0),
                            round_sat(div_quo[2], div_rem[2], r_dmag[2], div_tag[2]),
                            round_sat(div_quo[1], div_rem[1], r_dmag[1], div_tag[1]),
                            round_sat(div_quo[0], div_rem[0], r_dmag[0], div_tag[0])};
            end
        end
    end

    // ---------------- output register and skid ----------------
    assign take     = r_out_vld && i_m_axis_tready;
    assign pipe_out = adv && r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (take || !r_out_vld) begin
                r_out_vld <= r_skid_vld || pipe_out;
            end
            if (r_skid_vld) begin
                if (take || !r_out_vld) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (pipe_out && r_out_vld && !take) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_vld) begin
            r_out_data <= r_skid_vld ? r_skid_data : r_rdata;
            r_out_user <= r_skid_vld ? r_skid_user : r_rdeg;
        end
        if (!r_skid_vld) begin
            r_skid_data <= r_rdata;
            r_skid_user <= r_rdeg;
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_user;

`ifndef SYNTH
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_user) |-> (r_out_data == '0))
        else $error("degenerate result carries nonzero color");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds data while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_m_axis_tready))
        else $error("skid filled without a stalled output");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");
`endif

endmodule
